// ===== rtl/tfd_pkg.sv =====
// Shared types and constants for the typed frame deframer.
// Holds result codes, frame type codes, register indexes and port structs.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package tfd_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_HUNT_DROP = 3'd0,
    ST_START     = 3'd1,
    ST_FRAME     = 3'd2,
    ST_GOOD_END  = 3'd3,
    ST_BAD_END   = 3'd4,
    ST_BAD_TYPE  = 3'd5,
    ST_BAD_LEN   = 3'd6
  } status_e;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_START_FIRST  = 3'd0,
    REG_START_SECOND = 3'd1,
    REG_END_FIRST    = 3'd2,
    REG_END_SECOND   = 3'd3,
    REG_MAX_FRAME    = 3'd4,
    REG_MAX_RESP     = 3'd5,
    REG_MAX_CHUNK    = 3'd6
  } reg_idx_e;

  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned LenW   = 11;
  localparam int unsigned OfsW   = 10;

  // Frame type codes
  localparam logic [7:0] TYPE_RESPONSE = 8'h11;
  localparam logic [7:0] TYPE_MANIFEST = 8'h12;
  localparam logic [7:0] TYPE_CHUNK    = 8'h13;
  localparam logic [7:0] TYPE_BEACON   = 8'h14;

  // Fixed body sizes and per-type overheads
  localparam logic [15:0] MANIFEST_BODY = 16'd27;
  localparam logic [15:0] BEACON_BODY   = 16'd17;
  localparam logic [2:0]  RESP_OVERHEAD  = 3'd4;
  localparam logic [2:0]  CHUNK_OVERHEAD = 3'd5;
  localparam logic [2:0]  TRAILER_BYTES  = 3'd4;

  // Header offsets
  localparam logic [LenW-1:0] OFS_TYPE     = 11'd2;
  localparam logic [LenW-1:0] OFS_LEN_HIGH = 11'd4;
  localparam logic [LenW-1:0] OFS_LEN_LOW  = 11'd5;

  // Register reset values
  localparam logic [7:0]      RST_START_FIRST  = 8'd170;
  localparam logic [7:0]      RST_START_SECOND = 8'd85;
  localparam logic [7:0]      RST_END_FIRST    = 8'd13;
  localparam logic [7:0]      RST_END_SECOND   = 8'd10;
  localparam logic [LenW-1:0] RST_MAX_FRAME    = 11'd256;
  localparam logic [LenW-1:0] RST_MAX_RESP     = 11'd200;
  localparam logic [LenW-1:0] RST_MAX_CHUNK    = 11'd200;

  typedef struct packed {
    logic [7:0]      start_first;
    logic [7:0]      start_second;
    logic [7:0]      end_first;
    logic [7:0]      end_second;
    logic [LenW-1:0] max_frame;
    logic [LenW-1:0] max_resp;
    logic [LenW-1:0] max_chunk;
  } cfg_t;

  typedef struct packed {
    status_e         status;
    logic [OfsW-1:0] offset;
    logic [7:0]      kind;
    logic [LenW-1:0] total;
    logic            last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/tfd_cfg_regs.sv =====
// APB-style configuration register file of the typed frame deframer.
// Depends on tfd_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module tfd_cfg_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [tfd_pkg::AddrW-1:0] paddr,
  input  wire logic [tfd_pkg::DataW-1:0] pwdata,
  output logic      [tfd_pkg::DataW-1:0] prdata,
  output logic                           pready,
  output tfd_pkg::cfg_t                  cfg_o
);
  import tfd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_START_FIRST:  cfg_d.start_first  = pwdata[7:0];
        REG_START_SECOND: cfg_d.start_second = pwdata[7:0];
        REG_END_FIRST:    cfg_d.end_first    = pwdata[7:0];
        REG_END_SECOND:   cfg_d.end_second   = pwdata[7:0];
        REG_MAX_FRAME:    cfg_d.max_frame    = pwdata[LenW-1:0];
        REG_MAX_RESP:     cfg_d.max_resp     = pwdata[LenW-1:0];
        REG_MAX_CHUNK:    cfg_d.max_chunk    = pwdata[LenW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_first  <= RST_START_FIRST;
      cfg_q.start_second <= RST_START_SECOND;
      cfg_q.end_first    <= RST_END_FIRST;
      cfg_q.end_second   <= RST_END_SECOND;
      cfg_q.max_frame    <= RST_MAX_FRAME;
      cfg_q.max_resp     <= RST_MAX_RESP;
      cfg_q.max_chunk    <= RST_MAX_CHUNK;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_START_FIRST:  prdata = DataW'(cfg_q.start_first);
      REG_START_SECOND: prdata = DataW'(cfg_q.start_second);
      REG_END_FIRST:    prdata = DataW'(cfg_q.end_first);
      REG_END_SECOND:   prdata = DataW'(cfg_q.end_second);
      REG_MAX_FRAME:    prdata = DataW'(cfg_q.max_frame);
      REG_MAX_RESP:     prdata = DataW'(cfg_q.max_resp);
      REG_MAX_CHUNK:    prdata = DataW'(cfg_q.max_chunk);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/tfd_frame_core.sv =====
// Frame tracking state and the per-word decode of the typed frame deframer.
// Depends on tfd_pkg for status codes, frame types, cfg_t and res_t.
`timescale 1ns / 1ps
`default_nettype none

module tfd_frame_core #(
  parameter int unsigned HEADER_BYTES = 6,
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tfd_pkg::cfg_t cfg_i,
  input  wire logic          step_i,
  input  wire logic [7:0]    byte_i,
  output tfd_pkg::res_t      res_o
);
  import tfd_pkg::*;

  // Wide enough for a 16-bit body plus header, overhead and trailer,
  // and for the buffer size itself
  localparam int unsigned ExpMax = 65535 + HEADER_BYTES + 9;
  localparam int unsigned ExpW   = $clog2((ExpMax > BUFFER_BYTES ? ExpMax : BUFFER_BYTES) + 1);

  logic [LenW-1:0] rx_count_q, rx_count_d;
  logic            in_frame_q, in_frame_d;
  logic [7:0]      type_q, type_d;
  logic [7:0]      len_high_q, len_high_d;
  logic [7:0]      len_low_q, len_low_d;
  logic [7:0]      prev_q, prev_d;

  logic [LenW-1:0] count;
  logic [7:0]      cap_type, cap_high, cap_low;
  logic [15:0]     len;
  logic [15:0]     body;
  logic [2:0]      overhead;
  logic            known, bad_len, exp_ok;
  logic [ExpW-1:0] expected;

  // Capture header fields, including the one arriving this word
  assign count    = rx_count_q + LenW'(1);
  assign cap_type = (in_frame_q && rx_count_q == OFS_TYPE)     ? byte_i : type_q;
  assign cap_high = (in_frame_q && rx_count_q == OFS_LEN_HIGH) ? byte_i : len_high_q;
  assign cap_low  = (in_frame_q && rx_count_q == OFS_LEN_LOW)  ? byte_i : len_low_q;
  assign len      = {cap_high, cap_low};

  // Work out body size and bounds from the type
  always_comb begin
    known    = 1'b1;
    bad_len  = 1'b0;
    body     = '0;
    overhead = '0;
    case (cap_type)
      TYPE_RESPONSE: begin
        body     = len;
        overhead = RESP_OVERHEAD;
        bad_len  = len > 16'(cfg_i.max_resp);
      end
      TYPE_MANIFEST: body = MANIFEST_BODY;
      TYPE_CHUNK: begin
        body     = len;
        overhead = CHUNK_OVERHEAD;
        bad_len  = len > 16'(cfg_i.max_chunk);
      end
      TYPE_BEACON: body = BEACON_BODY;
      default: known = 1'b0;
    endcase
  end

  assign expected = ExpW'(HEADER_BYTES) + ExpW'(overhead) + ExpW'(body)
                  + ExpW'(TRAILER_BYTES);
  assign exp_ok   = (expected <= ExpW'(cfg_i.max_frame)) &&
                    (expected <= ExpW'(BUFFER_BYTES));

  // Decode one word
  always_comb begin
    rx_count_d = rx_count_q;
    in_frame_d = in_frame_q;
    type_d     = type_q;
    len_high_d = len_high_q;
    len_low_d  = len_low_q;
    prev_d     = prev_q;
    res_o      = '{status: ST_HUNT_DROP, offset: '0, kind: '0, total: '0, last: 1'b0};

    if (!in_frame_q) begin
      // Hunt for the start marker, no resync on a mismatch
      if (rx_count_q == '0 && byte_i == cfg_i.start_first) begin
        res_o.status = ST_START;
        rx_count_d   = LenW'(1);
      end else if (rx_count_q == LenW'(1) && byte_i == cfg_i.start_second) begin
        res_o.status = ST_START;
        res_o.offset = OfsW'(1);
        rx_count_d   = LenW'(2);
        in_frame_d   = 1'b1;
      end else begin
        rx_count_d = '0;
      end
    end else begin
      res_o.offset = rx_count_q[OfsW-1:0];
      res_o.status = ST_FRAME;
      type_d       = cap_type;
      len_high_d   = cap_high;
      len_low_d    = cap_low;
      rx_count_d   = count;

      if (count >= LenW'(HEADER_BYTES)) begin
        res_o.kind = cap_type;
        if (!known) begin
          res_o.status = ST_BAD_TYPE;
          res_o.last   = 1'b1;
        end else if (bad_len || !exp_ok) begin
          res_o.status = ST_BAD_LEN;
          res_o.last   = 1'b1;
        end else begin
          res_o.total = expected[LenW-1:0];
          if (ExpW'(count) >= expected) begin
            res_o.status = (prev_q == cfg_i.end_first && byte_i == cfg_i.end_second)
                         ? ST_GOOD_END : ST_BAD_END;
            res_o.last   = 1'b1;
          end
        end
      end

      // Drop the frame on its last word, else remember this byte
      if (res_o.last) begin
        rx_count_d = '0;
        in_frame_d = 1'b0;
        type_d     = '0;
        len_high_d = '0;
        len_low_d  = '0;
        prev_d     = '0;
      end else begin
        prev_d = byte_i;
      end
    end
  end

  // Advance the frame state once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_count_q <= '0;
      in_frame_q <= 1'b0;
      type_q     <= '0;
      len_high_q <= '0;
      len_low_q  <= '0;
      prev_q     <= '0;
    end else if (step_i) begin
      rx_count_q <= rx_count_d;
      in_frame_q <= in_frame_d;
      type_q     <= type_d;
      len_high_q <= len_high_d;
      len_low_q  <= len_low_d;
      prev_q     <= prev_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/typed_frame_deframer_core.sv =====
// Channel    | Handshake               | Payload
// -----------+-------------------------+---------------------------------------------
// rx in      | in_valid_i / in_ready_o | rx_byte_i
// result out | out_valid_o/out_ready_i | status_o echo_byte_o byte_offset_o
//            |                         | kind_code_o total_length_o frame_last_o
// config     | psel penable pwrite     | paddr pwdata prdata pready
//
// One word per cycle sustained while out_ready_i is high; a word passes the input
// register, then the result register, and its result is taken when out_ready_i is high.
// A word sits in the input register, is decoded against the frame state in
// one pass and lands in the result register while the state advances.
// A stalled result holds the input register; a new word is taken whenever the
// input register is empty or moves on in the same cycle.
// Reset clears the frame state to hunting and loads the default markers/bounds.
// Top level of the typed frame deframer; depends on tfd_pkg, tfd_cfg_regs
// and tfd_frame_core.
`timescale 1ns / 1ps
`default_nettype none

module typed_frame_deframer_core #(
  parameter int unsigned HEADER_BYTES = 6,
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [7:0]                rx_byte_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [2:0]                     status_o,
  output logic [7:0]                     echo_byte_o,
  output logic [tfd_pkg::OfsW-1:0]       byte_offset_o,
  output logic [7:0]                     kind_code_o,
  output logic [tfd_pkg::LenW-1:0]       total_length_o,
  output logic                           frame_last_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [tfd_pkg::AddrW-1:0] paddr,
  input  wire logic [tfd_pkg::DataW-1:0] pwdata,
  output logic      [tfd_pkg::DataW-1:0] prdata,
  output logic                           pready
);
  import tfd_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       step;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;

  logic       out_valid_q, out_valid_d;
  res_t       out_res_q;
  logic [7:0] out_byte_q;

  tfd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tfd_frame_core #(
    .HEADER_BYTES (HEADER_BYTES),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .byte_i (s1_byte_q),
    .res_o  (res)
  );

  // Move a word into the result register when it is free or being drained
  assign step       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || step;

  assign s1_valid_d  = (in_valid_i && in_ready_o) || (s1_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && !out_ready_i);

  // Hold the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= rx_byte_i;
    end
    if (step) begin
      out_res_q  <= res;
      out_byte_q <= s1_byte_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_res_q.status;
  assign echo_byte_o    = out_byte_q;
  assign byte_offset_o  = out_res_q.offset;
  assign kind_code_o    = out_res_q.kind;
  assign total_length_o = out_res_q.total;
  assign frame_last_o   = out_res_q.last;

  // An empty result register must never block the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  // A stalled word stays in the input register unchanged
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !step) |=> (s1_valid_q && $stable(s1_byte_q)))
    else $error("input register lost a stalled word");

  // Only end and discard codes close a frame
  a_last_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && frame_last_o) |->
      (status_o == ST_GOOD_END || status_o == ST_BAD_END ||
       status_o == ST_BAD_TYPE || status_o == ST_BAD_LEN))
    else $error("frame_last with a non-terminal status");

  // A hunting drop carries no frame information
  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_o == ST_HUNT_DROP) |->
      (byte_offset_o == '0 && kind_code_o == '0 && total_length_o == '0 &&
       !frame_last_o))
    else $error("hunting drop with frame fields set");

endmodule

`default_nettype wire
